[hdl/rational_arithmetic_unit_assert.svh]
// Assertion macros for the checker file of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RAU_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rational unit: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RAU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rational unit: next-cycle check failed");

`endif

[hdl/rau_pkg.sv]
// Shared constants, codes and control types of the rational arithmetic unit.
`default_nettype none

package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int ACT_W         = 3;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int SUM_W         = PROD_W + 1;
  localparam int MAG_W         = PROD_W;
  localparam int SHIFT_W       = $clog2(MAG_W);
  localparam int CNT_W         = $clog2(MAG_W);

  localparam int NUM_OUT_W     = 33;
  localparam int DEN_OUT_W     = 31;
  localparam int ORD_W         = 2;

  localparam int IN_W          = ACT_W + 4 * OPERAND_WIDTH;
  localparam int IN_TDATA_W    = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W         = NUM_OUT_W + DEN_OUT_W + ORD_W + 1;
  localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

  // Bit positions of the result fields in the output tdata.
  localparam int OUT_DEN_LSB   = NUM_OUT_W;
  localparam int OUT_ORD_LSB   = NUM_OUT_W + DEN_OUT_W;
  localparam int OUT_ERR_BIT   = OUT_ORD_LSB + ORD_W;

  localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CMP = 3'd4;

  localparam logic [ORD_W-1:0] ORDER_LESS    = 2'd0;
  localparam logic [ORD_W-1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [ORD_W-1:0] ORDER_GREATER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_GCD,
    ST_DIVN,
    ST_DSET,
    ST_DIVD,
    ST_FIN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic prep;
    logic gcd_step;
    logic gcd_take;
    logic div_init_num;
    logic div_init_den;
    logic div_step;
    logic num_store;
    logic den_store;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early;
    logic gcd_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hdl/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit: controller plus datapath.
//
//   Channel   Direction  Payload (low bit up)
//   s_axis    in         action, left_num, left_den, right_num, right_den
//   m_axis    out        result_num, result_den, order, error
//
// One request is worked at a time. Compare, error and unused codes go from capture,
// multiply and prepare straight to the output register. Other requests run the same
// setup, the binary gcd (one subtract or shift per cycle over 32-bit magnitudes, then
// a step to take the gcd) and two restoring divisions by the gcd on one shared divider,
// each followed by a store of its quotient, then a load of the output register once it
// is free. Reset is asynchronous and clears the controller and output valid flag.
// A stalled result stays in the output register while the next request is taken.
`default_nettype none

module rational_arithmetic_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // action[2:0], left_num[18:3], left_den[34:19], right_num[50:35], right_den[66:51]
  input  wire logic [rau_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // result_num[32:0], result_den[63:33], order[65:64], error[66]
  output logic [rau_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rau_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

[hdl/rau_ctrl.sv]
// Controller state machine sequencing the rational arithmetic datapath.
`default_nettype none

module rau_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire rau_pkg::sts_t sts_i,
  output rau_pkg::cmd_t      cmd_o
);

  localparam logic [rau_pkg::CNT_W-1:0] CntLast = rau_pkg::CNT_W'(rau_pkg::MAG_W - 1);

  rau_pkg::state_e state_q, state_d;
  logic [rau_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic cnt_last;

  assign cnt_last = (cnt_q == CntLast);

  // State and divider step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rau_pkg::ST_IDLE: if (s_tvalid_i) state_d = rau_pkg::ST_MUL;
      rau_pkg::ST_MUL:  state_d = rau_pkg::ST_PREP;
      rau_pkg::ST_PREP: state_d = sts_i.early ? rau_pkg::ST_DONE : rau_pkg::ST_GCD;
      rau_pkg::ST_GCD:  if (sts_i.gcd_done) state_d = rau_pkg::ST_DIVN;
      rau_pkg::ST_DIVN: if (cnt_last) state_d = rau_pkg::ST_DSET;
      rau_pkg::ST_DSET: state_d = rau_pkg::ST_DIVD;
      rau_pkg::ST_DIVD: if (cnt_last) state_d = rau_pkg::ST_FIN;
      rau_pkg::ST_FIN:  state_d = rau_pkg::ST_DONE;
      rau_pkg::ST_DONE: if (sts_i.out_free) state_d = rau_pkg::ST_IDLE;
      default:          state_d = rau_pkg::ST_IDLE;
    endcase
  end

  // Command outputs and step counter.
  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    cnt_d      = '0;
    case (state_q)
      rau_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      rau_pkg::ST_MUL:  cmd_o.mul  = 1'b1;
      rau_pkg::ST_PREP: cmd_o.prep = 1'b1;
      rau_pkg::ST_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.gcd_take     = 1'b1;
          cmd_o.div_init_num = 1'b1;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      rau_pkg::ST_DIVN: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      rau_pkg::ST_DSET: begin
        cmd_o.num_store    = 1'b1;
        cmd_o.div_init_den = 1'b1;
      end
      rau_pkg::ST_DIVD: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      rau_pkg::ST_FIN:  cmd_o.den_store = 1'b1;
      rau_pkg::ST_DONE: cmd_o.out_load  = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/rau_datapath.sv]
// Datapath: operand capture, cross products, binary gcd, divider and result register.
`default_nettype none

module rau_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [rau_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  output logic                                 m_tvalid_o,
  input  wire logic                            m_tready_i,
  output logic [rau_pkg::OUT_TDATA_W-1:0]      m_tdata_o,
  input  wire rau_pkg::cmd_t                   cmd_i,
  output rau_pkg::sts_t                        sts_o
);

  localparam int OW = rau_pkg::OPERAND_WIDTH;
  localparam int MW = rau_pkg::MAG_W;

  // Captured operands.
  logic [rau_pkg::ACT_W-1:0] act_q;
  logic signed [OW-1:0] ln_q, ld_q, rn_q, rd_q;

  // Cross products.
  logic signed [rau_pkg::PROD_W-1:0] p1_q, p2_q, p3_q;
  logic signed [OW-1:0] mul_b;

  // Reduction state.
  logic          neg_q;
  logic [MW-1:0] mag_q, dmag_q, a_q, b_q, g_q;
  logic [rau_pkg::SHIFT_W-1:0] k_q;
  logic [MW:0]   rem_q;
  logic [MW-1:0] quo_q;

  // Result and output registers.
  logic signed [rau_pkg::NUM_OUT_W-1:0] res_num_q;
  logic [rau_pkg::DEN_OUT_W-1:0] res_den_q;
  logic [rau_pkg::ORD_W-1:0]     res_ord_q;
  logic                          res_err_q;
  logic                          out_valid_q;
  logic [rau_pkg::OUT_TDATA_W-1:0] out_data_q;

  // Operand capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= s_tdata_i[rau_pkg::ACT_W-1:0];
      ln_q  <= s_tdata_i[rau_pkg::ACT_W          +: OW];
      ld_q  <= s_tdata_i[rau_pkg::ACT_W + OW     +: OW];
      rn_q  <= s_tdata_i[rau_pkg::ACT_W + 2 * OW +: OW];
      rd_q  <= s_tdata_i[rau_pkg::ACT_W + 3 * OW +: OW];
    end
  end

  // Three parallel signed multiplies, registered.
  assign mul_b = (act_q == rau_pkg::ACT_MUL) ? rn_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q <= ln_q * mul_b;
      p2_q <= ld_q * rn_q;
      p3_q <= ld_q * rd_q;
    end
  end

  // Early outcomes: unused code, zero operand denominator, compare, divide by zero.
  logic unused_act, zero_den, is_cmp, div_zero;
  logic cmp_flip, cmp_lt;
  logic [rau_pkg::ORD_W-1:0] cmp_ord;

  assign unused_act = (act_q > rau_pkg::ACT_CMP);
  assign zero_den   = (ld_q == '0) || (rd_q == '0);
  assign is_cmp     = (act_q == rau_pkg::ACT_CMP);
  assign div_zero   = (act_q == rau_pkg::ACT_DIV) && (rn_q == '0);
  assign cmp_flip   = ld_q[OW-1] ^ rd_q[OW-1];
  assign cmp_lt     = (p1_q < p2_q);

  always_comb begin
    if (p1_q == p2_q) begin
      cmp_ord = rau_pkg::ORDER_EQUAL;
    end else if (cmp_lt != cmp_flip) begin
      cmp_ord = rau_pkg::ORDER_LESS;
    end else begin
      cmp_ord = rau_pkg::ORDER_GREATER;
    end
  end

  // Raw numerator and denominator, then sign moved onto the numerator.
  logic signed [rau_pkg::SUM_W-1:0]  p1_x, p2_x, num_raw, num_fix;
  logic signed [rau_pkg::PROD_W-1:0] den_raw;
  logic [MW-1:0] den_mag, num_mag;

  assign p1_x = {p1_q[rau_pkg::PROD_W-1], p1_q};
  assign p2_x = {p2_q[rau_pkg::PROD_W-1], p2_q};

  always_comb begin
    case (act_q)
      rau_pkg::ACT_ADD: num_raw = p1_x + p2_x;
      rau_pkg::ACT_SUB: num_raw = p1_x - p2_x;
      default:          num_raw = p1_x;
    endcase
  end

  assign den_raw = (act_q == rau_pkg::ACT_DIV) ? p2_q : p3_q;
  assign num_fix = den_raw[rau_pkg::PROD_W-1] ? -num_raw : num_raw;
  assign den_mag = MW'(den_raw[rau_pkg::PROD_W-1] ? -den_raw : den_raw);
  assign num_mag = MW'(num_fix[rau_pkg::SUM_W-1] ? -num_fix : num_fix);

  // Binary gcd step; done once either value reaches zero.
  logic gcd_done;
  logic [MW-1:0] g_base;

  assign gcd_done = (a_q == '0) || (b_q == '0);
  assign g_base   = (a_q == '0) ? b_q : a_q;

  // Restoring divider step against the gcd.
  logic [MW:0] rem_sh, rem_diff;

  assign rem_sh   = {rem_q[MW-1:0], quo_q[MW-1]};
  assign rem_diff = rem_sh - {1'b0, g_q};

  // Signed numerator from the quotient.
  logic signed [rau_pkg::SUM_W-1:0] quo_x, num_val;

  assign quo_x   = {1'b0, quo_q};
  assign num_val = neg_q ? -quo_x : quo_x;

  // Setup, gcd and divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      neg_q  <= num_fix[rau_pkg::SUM_W-1];
      mag_q  <= num_mag;
      dmag_q <= den_mag;
      a_q    <= num_mag;
      b_q    <= den_mag;
      k_q    <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end
    if (cmd_i.gcd_take) begin
      g_q <= g_base << k_q;
    end
    if (cmd_i.div_init_num || cmd_i.div_init_den) begin
      rem_q <= '0;
      quo_q <= cmd_i.div_init_den ? dmag_q : mag_q;
    end else if (cmd_i.div_step) begin
      if (!rem_diff[MW]) begin
        rem_q <= rem_diff;
        quo_q <= {quo_q[MW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[MW-2:0], 1'b0};
      end
    end
  end

  // Result fields: early outcomes at setup, quotients after each division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      res_num_q <= '0;
      res_den_q <= '0;
      res_ord_q <= is_cmp && !unused_act && !zero_den ? cmp_ord : rau_pkg::ORDER_EQUAL;
      res_err_q <= !unused_act && (zero_den || div_zero);
    end
    if (cmd_i.num_store) begin
      res_num_q <= rau_pkg::NUM_OUT_W'(num_val);
    end
    if (cmd_i.den_store) begin
      res_den_q <= rau_pkg::DEN_OUT_W'(quo_q);
    end
  end

  // Output register with its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= rau_pkg::OUT_TDATA_W'({res_err_q, res_ord_q, res_den_q, res_num_q});
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  assign sts_o.early    = unused_act || zero_den || is_cmp || div_zero;
  assign sts_o.gcd_done = gcd_done;
  assign sts_o.out_free = !out_valid_q || m_tready_i;

endmodule

`default_nettype wire

[hdl/rau_checker.sv]
// Port-level checker of the rational arithmetic unit, bound to the top level.
`default_nettype none

`include "rational_arithmetic_unit_assert.svh"

module rau_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [rau_pkg::NUM_OUT_W-1:0] num;
  logic [rau_pkg::DEN_OUT_W-1:0] den;
  logic [rau_pkg::ORD_W-1:0]     ord;
  logic                          err;

  assign num = m_tdata[rau_pkg::NUM_OUT_W-1:0];
  assign den = m_tdata[rau_pkg::OUT_DEN_LSB +: rau_pkg::DEN_OUT_W];
  assign ord = m_tdata[rau_pkg::OUT_ORD_LSB +: rau_pkg::ORD_W];
  assign err = m_tdata[rau_pkg::OUT_ERR_BIT];

  // A stalled result holds.
  `RAU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // An error result carries a zero fraction and the neutral order.
  `RAU_ASSERT_IMPLY(a_err_clean, clk_i, rst_ni, m_tvalid && err, num == '0 && den == '0 && ord == rau_pkg::ORDER_EQUAL)

  // A fraction result never carries a compare outcome.
  `RAU_ASSERT_IMPLY(a_frac_order, clk_i, rst_ni, m_tvalid && den != '0, ord == rau_pkg::ORDER_EQUAL && !err)

  // A zero fraction always reduces to zero over one.
  `RAU_ASSERT_IMPLY(a_zero_reduced, clk_i, rst_ni, m_tvalid && num == '0 && den != '0, den == rau_pkg::DEN_OUT_W'(1))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
